### hw/rtl/x86_16_subset_execute_unit_assert.svh
// assertion helpers for the execute unit, clocked on aclk with aresetn low as disable
`ifndef X86_16_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define X86_16_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define X86EU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define X86EU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/x86eu_pkg.sv
package x86eu_pkg;

    // byte memory size, a power of two from 256 up to 65536
    localparam int MEM_BYTES  = 65536;
    localparam int MEM_AW     = $clog2(MEM_BYTES);
    localparam int BANK_DEPTH = MEM_BYTES / 2;
    localparam int BANK_AW    = MEM_AW - 1;

    localparam int NUM_REGS = 8;
    localparam int REG_AW   = $clog2(NUM_REGS);

    // operation codes
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_CMP = 3'd3;
    localparam logic [2:0] OP_JNE = 3'd4;

    // source kinds
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_IMM  = 2'd1;
    localparam logic [1:0] SRC_REG  = 2'd2;
    localparam logic [1:0] SRC_MEM  = 2'd3;

    localparam logic [3:0] REG_FIRST = 4'd1;
    localparam logic [3:0] REG_LAST  = 4'd8;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] displacement;
        logic [3:0]  ea_reg_b;
        logic [3:0]  ea_reg_a;
        logic [15:0] immediate;
        logic [3:0]  src_reg;
        logic [3:0]  dst_reg;
        logic [2:0]  inst_length;
    } in_data_t;

    typedef struct packed {
        logic [1:0] src_kind;
        logic       dst_is_memory;
        logic [2:0] mode;
    } in_user_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic        mem_written;
        logic        reg_written;
        logic [15:0] result_value;
        logic        sign_flag;
        logic        zero_flag;
        logic [15:0] next_ip;
    } out_data_t;

    function automatic logic reg_ok(input logic [3:0] r);
        return (r >= REG_FIRST) && (r <= REG_LAST);
    endfunction

    function automatic logic [REG_AW-1:0] reg_idx(input logic [3:0] r);
        logic [3:0] d;
        d = r - REG_FIRST;
        return d[REG_AW-1:0];
    endfunction

endpackage

### hw/rtl/x86_16_subset_execute_unit.sv
// sequence: register file read of the address registers, then the source/destination and
//   memory bank reads, then write-back, which waits while the output register holds a
//   result not yet taken on m_tready; a new instruction starts only after write-back
// reset: aresetn low synchronously clears control state; afterwards a clearing pass over
//   all MEM_BYTES/2 (32768) bank rows zeroes the memory banks and register file, s_tready held low
`include "x86_16_subset_execute_unit_assert.svh"

module x86_16_subset_execute_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // inst_length, dst_reg, src_reg, immediate, ea_reg_a, ea_reg_b, displacement, zero pad
    input  x86eu_pkg::in_data_t   s_tdata,
    // mode, dst_is_memory, src_kind
    input  x86eu_pkg::in_user_t   s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // next_ip, zero_flag, sign_flag, result_value, reg_written, mem_written, zero pad
    output x86eu_pkg::out_data_t  m_tdata
);
    import x86eu_pkg::*;

    // sequencer codes
    localparam logic [1:0] ST_CLEAR = 2'd0;   // post-reset memory sweep
    localparam logic [1:0] ST_IDLE  = 2'd1;   // take next instruction, read address regs
    localparam logic [1:0] ST_RD1   = 2'd2;   // form address, read src/dst regs and memory
    localparam logic [1:0] ST_EXEC  = 2'd3;   // compute, write back, load output

    logic [1:0]         state_reg, state_next;
    logic [BANK_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // input skid buffer: one transaction can wait while another is in work
    logic     buf_valid_reg, buf_valid_next;
    in_data_t buf_data_reg;
    in_user_t buf_user_reg;

    // instruction in work
    in_data_t cur_data_reg;
    in_user_t cur_user_reg;

    // architectural scalars
    logic [15:0] ip_reg, ip_next;
    logic        zf_reg, zf_next;
    logic        sf_reg, sf_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_data_t out_data_reg;

    logic take;
    logic exec_fire;

    assign take      = (state_reg == ST_IDLE) && buf_valid_reg;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign s_tready  = !buf_valid_reg && (state_reg != ST_CLEAR);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // ---------------- register file: two read ports, one write port
    logic [15:0]       rf_mem [0:NUM_REGS-1];
    logic [REG_AW-1:0] rf_ra, rf_rb, rf_widx;
    logic              rf_ra_ok, rf_rb_ok;
    logic              rf_we;
    logic [15:0]       rf_wdata;
    logic [15:0]       rf_a_rdata_reg, rf_b_rdata_reg;
    logic              rf_a_ok_reg, rf_b_ok_reg;

    always_comb begin
        if (state_reg == ST_IDLE) begin
            // effective address terms of the waiting instruction
            rf_ra    = reg_idx(buf_data_reg.ea_reg_a);
            rf_rb    = reg_idx(buf_data_reg.ea_reg_b);
            rf_ra_ok = reg_ok(buf_data_reg.ea_reg_a);
            rf_rb_ok = reg_ok(buf_data_reg.ea_reg_b);
        end else begin
            // source operand and left operand
            rf_ra    = reg_idx(cur_data_reg.src_reg);
            rf_rb    = reg_idx(cur_data_reg.dst_reg);
            rf_ra_ok = reg_ok(cur_data_reg.src_reg);
            rf_rb_ok = reg_ok(cur_data_reg.dst_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_widx] <= rf_wdata;
        end
        rf_a_rdata_reg <= rf_mem[rf_ra];
        rf_b_rdata_reg <= rf_mem[rf_rb];
        rf_a_ok_reg    <= rf_ra_ok;
        rf_b_ok_reg    <= rf_rb_ok;
    end

    logic [15:0] reg_a_val, reg_b_val;
    assign reg_a_val = rf_a_ok_reg ? rf_a_rdata_reg : 16'd0;
    assign reg_b_val = rf_b_ok_reg ? rf_b_rdata_reg : 16'd0;

    // ---------------- byte memory as two banks: even and odd addresses
    logic [7:0] mem_even [0:BANK_DEPTH-1];
    logic [7:0] mem_odd  [0:BANK_DEPTH-1];

    logic [15:0]        ea;
    logic [MEM_AW-1:0]  mem_addr, mem_addr_inc;
    logic [BANK_AW-1:0] even_idx, odd_idx;
    logic [BANK_AW-1:0] even_idx_reg, odd_idx_reg;
    logic               addr_odd_reg;
    logic [7:0]         even_rdata_reg, odd_rdata_reg;

    logic [BANK_AW-1:0] even_widx, odd_widx;
    logic               even_we, odd_we;
    logic [7:0]         even_wdata, odd_wdata;

    // in ST_RD1 the port data holds the two address registers
    assign ea           = cur_data_reg.displacement + reg_a_val + reg_b_val;
    assign mem_addr     = ea[MEM_AW-1:0];
    assign mem_addr_inc = mem_addr + MEM_AW'(1);
    // a word at an odd address takes its high byte from the next even row
    assign even_idx     = mem_addr_inc[MEM_AW-1:1];
    assign odd_idx      = mem_addr[MEM_AW-1:1];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD1) begin
            even_idx_reg <= even_idx;
            odd_idx_reg  <= odd_idx;
            addr_odd_reg <= mem_addr[0];
        end
    end

    // read data is held while the execute stage waits on the output
    always_ff @(posedge aclk) begin
        if (even_we) begin
            mem_even[even_widx] <= even_wdata;
        end
        if (state_reg == ST_RD1) begin
            even_rdata_reg <= mem_even[even_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (odd_we) begin
            mem_odd[odd_widx] <= odd_wdata;
        end
        if (state_reg == ST_RD1) begin
            odd_rdata_reg <= mem_odd[odd_idx];
        end
    end

    logic [15:0] mem_word;
    assign mem_word = addr_odd_reg ? {even_rdata_reg, odd_rdata_reg}
                                   : {odd_rdata_reg, even_rdata_reg};

    // ---------------- execute
    logic [15:0] src_val, lhs_val, sum_val, diff_val, result;
    logic [15:0] ip_step;
    logic        dst_ok;
    logic        rw, mw, flags_upd;

    always_comb begin
        case (cur_user_reg.src_kind)
            SRC_IMM: src_val = cur_data_reg.immediate;
            SRC_REG: src_val = reg_a_val;
            SRC_MEM: src_val = mem_word;
            default: src_val = 16'd0;
        endcase
    end

    assign lhs_val  = reg_b_val;
    assign sum_val  = lhs_val + src_val;
    assign diff_val = lhs_val - src_val;
    assign dst_ok   = reg_ok(cur_data_reg.dst_reg);
    assign ip_step  = ip_reg + 16'(cur_data_reg.inst_length);

    always_comb begin
        result    = 16'd0;
        rw        = 1'b0;
        mw        = 1'b0;
        flags_upd = 1'b0;
        ip_next   = ip_step;
        unique case (cur_user_reg.mode)
            OP_MOV: begin
                result = src_val;
                mw     = cur_user_reg.dst_is_memory;
                rw     = !cur_user_reg.dst_is_memory && dst_ok;
            end
            OP_ADD: begin
                result    = sum_val;
                rw        = dst_ok;
                flags_upd = 1'b1;
            end
            OP_SUB: begin
                result    = diff_val;
                rw        = dst_ok;
                flags_upd = 1'b1;
            end
            OP_CMP: begin
                result    = diff_val;
                flags_upd = 1'b1;
            end
            OP_JNE: begin
                if (!zf_reg) begin
                    ip_next = ip_step + cur_data_reg.immediate;
                end
            end
            default: begin
                // no effect beyond the instruction pointer
            end
        endcase
        zf_next = flags_upd ? (result == 16'd0) : zf_reg;
        sf_next = flags_upd ? result[15] : sf_reg;
    end

    // write ports: clearing sweep, else execute write-back
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            rf_we      = 1'b1;
            rf_widx    = clr_cnt_reg[REG_AW-1:0];
            rf_wdata   = 16'd0;
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_widx  = clr_cnt_reg;
            odd_widx   = clr_cnt_reg;
            even_wdata = 8'd0;
            odd_wdata  = 8'd0;
        end else begin
            rf_we      = exec_fire && rw;
            rf_widx    = reg_idx(cur_data_reg.dst_reg);
            rf_wdata   = result;
            even_we    = exec_fire && mw;
            odd_we     = exec_fire && mw;
            even_widx  = even_idx_reg;
            odd_widx   = odd_idx_reg;
            // low byte goes to the bank of the address parity
            even_wdata = addr_odd_reg ? result[15:8] : result[7:0];
            odd_wdata  = addr_odd_reg ? result[7:0]  : result[15:8];
        end
    end

    // ---------------- sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + BANK_AW'(1);
                if (clr_cnt_reg == BANK_AW'(BANK_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take) begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        buf_valid_next = buf_valid_reg;
        if (s_tvalid && s_tready) begin
            buf_valid_next = 1'b1;
        end else if (take) begin
            buf_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (exec_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ip_reg        <= 16'd0;
            zf_reg        <= 1'b0;
            sf_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire) begin
                ip_reg <= ip_next;
                zf_reg <= zf_next;
                sf_reg <= sf_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            buf_data_reg <= s_tdata;
            buf_user_reg <= s_tuser;
        end
        if (take) begin
            cur_data_reg <= buf_data_reg;
            cur_user_reg <= buf_user_reg;
        end
        if (exec_fire) begin
            out_data_reg.pad          <= '0;
            out_data_reg.mem_written  <= mw;
            out_data_reg.reg_written  <= rw;
            out_data_reg.result_value <= result;
            out_data_reg.sign_flag    <= sf_next;
            out_data_reg.zero_flag    <= zf_next;
            out_data_reg.next_ip      <= ip_next;
        end
    end

    // ---------------- checks
    `X86EU_ASSERT_NOW(a_no_accept_in_clear, state_reg == ST_CLEAR, !s_tready, "accept during clearing pass")
    `X86EU_ASSERT_NEXT(a_exec_loads_out, exec_fire, out_valid_reg && (state_reg == ST_IDLE), "write-back did not present a result")
    `X86EU_ASSERT_NOW(a_single_dest, out_valid_reg, !(out_data_reg.reg_written && out_data_reg.mem_written), "register and memory both written")
    `X86EU_ASSERT_NEXT(a_accept_fills_buf, s_tvalid && s_tready, buf_valid_reg, "accepted transaction not buffered")

endmodule

### dv/x86_16_subset_execute_unit_checker.sv
module x86_16_subset_execute_unit_checker
    import x86eu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tready,
    input  in_data_t  s_tdata,
    input  in_user_t  s_tuser,
    input  logic      m_tvalid,
    input  logic      m_tready,
    input  out_data_t m_tdata,
    output int        n_pending,
    output int        n_errors,
    output int        n_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // architectural state as the unit should see it
    logic [15:0] gpr [NUM_REGS];
    logic [15:0] ip;
    logic        zf;
    logic        sf;
    logic [7:0]  mem_bytes [MEM_BYTES];

    out_data_t   exec_results_q [$];
    out_data_t   want;
    int          err_count   = 0;
    int          check_count = 0;
    int          pend_count  = 0;

    assign n_pending = pend_count;
    assign n_errors  = err_count;
    assign n_checked = check_count;

    function automatic logic reg_in_range(input logic [3:0] r);
        return (r >= REG_FIRST) && (r <= REG_LAST);
    endfunction

    // registers outside ax..di read as zero
    function automatic logic [15:0] gpr_value(input logic [3:0] r);
        if (reg_in_range(r)) begin
            return gpr[r - REG_FIRST];
        end
        return 16'h0000;
    endfunction

    function automatic logic [15:0] eff_addr(input in_data_t d);
        logic [15:0] a;
        a = d.displacement + gpr_value(d.ea_reg_a) + gpr_value(d.ea_reg_b);
        return a;
    endfunction

    function automatic logic [15:0] source_word(input in_data_t d, input in_user_t u);
        logic [15:0] a;
        int          lo;
        int          hi;
        case (u.src_kind)
            SRC_IMM: begin
                return d.immediate;
            end
            SRC_REG: begin
                return gpr_value(d.src_reg);
            end
            SRC_MEM: begin
                a  = eff_addr(d);
                lo = int'(a) % MEM_BYTES;
                hi = (int'(a) + 1) % MEM_BYTES;
                return {mem_bytes[hi], mem_bytes[lo]};
            end
            default: begin
                return 16'h0000;
            end
        endcase
    endfunction

    // runs one instruction against the state and returns what the unit should report
    function automatic out_data_t execute_instr(input in_data_t d, input in_user_t u);
        out_data_t   r;
        logic [15:0] lhs;
        logic [15:0] val;
        logic [15:0] a;
        int          lo;
        int          hi;
        r  = '0;
        ip = ip + 16'(d.inst_length);
        case (u.mode)
            OP_MOV: begin
                val            = source_word(d, u);
                r.result_value = val;
                if (u.dst_is_memory) begin
                    a  = eff_addr(d);
                    lo = int'(a) % MEM_BYTES;
                    hi = (int'(a) + 1) % MEM_BYTES;
                    mem_bytes[lo] = val[7:0];
                    mem_bytes[hi] = val[15:8];
                    r.mem_written = 1'b1;
                end else if (reg_in_range(d.dst_reg)) begin
                    gpr[d.dst_reg - REG_FIRST] = val;
                    r.reg_written = 1'b1;
                end
            end
            OP_ADD, OP_SUB, OP_CMP: begin
                lhs = gpr_value(d.dst_reg);
                val = source_word(d, u);
                r.result_value = (u.mode == OP_ADD) ? lhs + val : lhs - val;
                if (u.mode != OP_CMP && reg_in_range(d.dst_reg)) begin
                    gpr[d.dst_reg - REG_FIRST] = r.result_value;
                    r.reg_written = 1'b1;
                end
                zf = (r.result_value == 16'h0000);
                sf = r.result_value[15];
            end
            OP_JNE: begin
                if (!zf) begin
                    ip = ip + d.immediate;
                end
            end
            default: begin
            end
        endcase
        r.next_ip   = ip;
        r.zero_flag = zf;
        r.sign_flag = sf;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [15:0] exp_val,
                                input logic [15:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_val, got_val);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (gpr[i]) gpr[i] = 16'h0000;
            foreach (mem_bytes[i]) mem_bytes[i] = 8'h00;
            ip = 16'h0000;
            zf = 1'b0;
            sf = 1'b0;
            exec_results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (exec_results_q.size() == 0) begin
                    $error("result transaction with nothing outstanding: %h", m_tdata);
                    err_count++;
                end else begin
                    want = exec_results_q.pop_front();
                    report_field("next_ip", want.next_ip, m_tdata.next_ip);
                    report_field("zero_flag", 16'(want.zero_flag), 16'(m_tdata.zero_flag));
                    report_field("sign_flag", 16'(want.sign_flag), 16'(m_tdata.sign_flag));
                    report_field("result_value", want.result_value, m_tdata.result_value);
                    report_field("reg_written", 16'(want.reg_written),
                                 16'(m_tdata.reg_written));
                    report_field("mem_written", 16'(want.mem_written),
                                 16'(m_tdata.mem_written));
                    check_count++;
                end
            end
            if (s_tvalid && s_tready) begin
                exec_results_q.push_back(execute_instr(s_tdata, s_tuser));
            end
        end
        pend_count = exec_results_q.size();
    end

endmodule

### dv/x86_16_subset_execute_unit_test.sv
module x86_16_subset_execute_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import x86eu_pkg::*;

    // modes without a package name: all of them only move the instruction pointer
    localparam logic [2:0] OP_OTHER = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // register numbers as the instruction encodes them
    localparam logic [3:0] REG_NONE   = 4'd0;
    localparam logic [3:0] REG_AX     = 4'd1;
    localparam logic [3:0] REG_CX     = 4'd2;
    localparam logic [3:0] REG_DX     = 4'd3;
    localparam logic [3:0] REG_BX     = 4'd4;
    localparam logic [3:0] REG_SP     = 4'd5;
    localparam logic [3:0] REG_BP     = 4'd6;
    localparam logic [3:0] REG_SI     = 4'd7;
    localparam logic [3:0] REG_DI     = 4'd8;
    localparam logic [3:0] REG_BAD_LO = 4'd9;
    localparam logic [3:0] REG_BAD_HI = 4'd15;

    localparam int RANDOM_ROUNDS = 820;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_TOGGLE, RDY_STALL} rdy_style_t;

    // every block input starts at a known value
    logic      aclk     = 1'b0;
    logic      aresetn  = 1'b0;
    logic      s_tvalid = 1'b0;
    logic      s_tready;
    in_data_t  s_tdata  = '0;
    in_user_t  s_tuser  = '0;
    logic      m_tvalid;
    logic      m_tready = 1'b0;
    out_data_t m_tdata;

    int n_pending;
    int n_errors;
    int n_checked;

    // sender bookkeeping
    int burst_left = 0;
    int n_sent     = 0;
    int n_stores   = 0;
    int n_branches = 0;

    // receiver stall pattern
    rdy_style_t rdy_style    = RDY_ALWAYS;
    int         rdy_seg_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    x86_16_subset_execute_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    x86_16_subset_execute_unit_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_pending (n_pending),
        .n_errors  (n_errors),
        .n_checked (n_checked)
    );

    // result side: segments of always-ready, random, toggling and short full stalls
    always @(posedge aclk) begin
        if (rdy_seg_left == 0) begin
            rdy_style    = rdy_style_t'($urandom_range(RDY_ALWAYS, RDY_STALL));
            rdy_seg_left = (rdy_style == RDY_STALL) ? $urandom_range(1, 10)
                                                    : $urandom_range(4, 60);
        end
        rdy_seg_left--;
        case (rdy_style)
            RDY_ALWAYS: begin
                m_tready <= 1'b1;
            end
            RDY_RANDOM: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            RDY_TOGGLE: begin
                m_tready <= ~m_tready;
            end
            default: begin
                m_tready <= 1'b0;
            end
        endcase
    end

    // one instruction transaction on the input side, then the burst/gap decision;
    // s_tvalid is only lowered when a gap follows
    task automatic issue(input logic [2:0] mode, input logic [2:0] len, input logic dmem,
                         input logic [3:0] dreg, input logic [1:0] skind,
                         input logic [3:0] sreg, input logic [15:0] imm,
                         input logic [3:0] ea_a, input logic [3:0] ea_b,
                         input logic [15:0] disp);
        in_data_t d;
        in_user_t u;
        int       gap;
        d               = '0;
        d.inst_length   = len;
        d.dst_reg       = dreg;
        d.src_reg       = sreg;
        d.immediate     = imm;
        d.ea_reg_a      = ea_a;
        d.ea_reg_b      = ea_b;
        d.displacement  = disp;
        u.mode          = mode;
        u.dst_is_memory = dmem;
        u.src_kind      = skind;
        s_tdata  <= d;
        s_tuser  <= u;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        if (mode == OP_MOV && dmem) n_stores++;
        if (mode == OP_JNE) n_branches++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // hold the input side idle until every issued instruction has reported back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    // mostly ax..di, now and then a number outside the register file
    function automatic logic [3:0] pick_reg();
        if ($urandom_range(0, 9) != 0) begin
            return 4'($urandom_range(REG_AX, REG_DI));
        end
        return ($urandom_range(0, 1) != 0) ? REG_NONE
                                           : 4'($urandom_range(REG_BAD_LO, REG_BAD_HI));
    endfunction

    // address terms are often absent so that accesses land in a small window
    function automatic logic [3:0] pick_ea_reg();
        if ($urandom_range(0, 99) < 55) begin
            return REG_NONE;
        end
        return pick_reg();
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // low window, top window (word straddles the wrap) or anywhere
    function automatic logic [15:0] pick_disp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($urandom_range(0, 31));
        if (r < 7) return 16'($urandom_range(16'hFFE0, 16'hFFFF));
        return 16'($urandom);
    endfunction

    function automatic logic [2:0] pick_mode();
        if ($urandom_range(0, 99) < 85) begin
            return 3'($urandom_range(OP_MOV, OP_JNE));
        end
        return 3'($urandom_range(OP_OTHER, OP_RSVD7));
    endfunction

    // generous limit: clearing pass after reset plus every transaction at its slowest
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [3:0]  ea_a;
        logic [3:0]  ea_b;
        logic [15:0] disp;
        logic [3:0]  r;
        int          k;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: value extremes
        issue(OP_MOV, 3, 0, REG_AX, SRC_IMM, REG_NONE, 16'hFFFF, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_MOV, 3, 0, REG_CX, SRC_IMM, REG_NONE, 16'h8000, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_MOV, 3, 0, REG_DI, SRC_IMM, REG_NONE, 16'h0001, REG_NONE, REG_NONE, 16'h0000);
        // word store at the top address, high byte wraps to address zero
        issue(OP_MOV, 4, 1, REG_NONE, SRC_REG, REG_AX, 16'h0000, REG_NONE, REG_NONE, 16'hFFFF);
        issue(OP_MOV, 4, 0, REG_DX, SRC_MEM, REG_NONE, 16'h0000, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_MOV, 4, 0, REG_SI, SRC_MEM, REG_NONE, 16'h0000, REG_NONE, REG_NONE, 16'hFFFF);
        // add to zero sets zf, jne falls through
        issue(OP_ADD, 3, 0, REG_AX, SRC_IMM, REG_NONE, 16'h0001, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_JNE, 2, 0, REG_NONE, SRC_NONE, REG_NONE, 16'h0010, REG_NONE, REG_NONE, 16'h0000);
        // borrow to 0xffff sets sf, backward branch taken
        issue(OP_SUB, 3, 0, REG_BX, SRC_IMM, REG_NONE, 16'h0001, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_JNE, 2, 0, REG_NONE, SRC_NONE, REG_NONE, 16'hFFF0, REG_NONE, REG_NONE, 16'h0000);
        // cmp against itself and against an absent source
        issue(OP_CMP, 2, 0, REG_CX, SRC_REG, REG_CX, 16'h0000, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_CMP, 2, 0, REG_CX, SRC_NONE, REG_NONE, 16'h0000, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_JNE, 2, 0, REG_NONE, SRC_NONE, REG_NONE, 16'h7FFF, REG_NONE, REG_NONE, 16'h0000);
        // destinations outside the register file drop the write
        issue(OP_MOV, 2, 0, REG_NONE, SRC_IMM, REG_NONE, 16'h1234, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_MOV, 2, 0, REG_BAD_HI, SRC_IMM, REG_NONE, 16'h5678, REG_NONE, REG_NONE, 16'h0000);
        // invalid destination for add with the memory flag set: zero lhs, flag ignored
        issue(OP_ADD, 2, 1, REG_BAD_LO, SRC_REG, REG_DI, 16'h0000, REG_NONE, REG_NONE, 16'h0000);
        // invalid source register reads as zero
        issue(OP_SUB, 2, 0, REG_DI, SRC_REG, REG_BAD_HI, 16'h0000, REG_NONE, REG_NONE, 16'h0000);
        // two address registers plus displacement wrapping past 0xffff
        issue(OP_MOV, 6, 1, REG_NONE, SRC_IMM, REG_NONE, 16'hA5C3, REG_BX, REG_SI, 16'h0002);
        // invalid address register is left out of the sum
        issue(OP_MOV, 6, 0, REG_SP, SRC_MEM, REG_NONE, 16'h0000, REG_BAD_LO, REG_DI, 16'hFFFF);
        // memory to memory move
        issue(OP_MOV, 5, 1, REG_NONE, SRC_MEM, REG_NONE, 16'h0000, REG_SP, REG_NONE, 16'h0100);
        // modes with no effect
        issue(OP_OTHER, 1, 1, REG_AX, SRC_IMM, REG_AX, 16'hFFFF, REG_AX, REG_AX, 16'hFFFF);
        issue(OP_RSVD6, 1, 0, REG_BX, SRC_REG, REG_CX, 16'h0000, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_RSVD7, 7, 1, REG_BAD_HI, SRC_MEM, REG_BAD_HI, 16'hFFFF, REG_BAD_HI,
              REG_BAD_HI, 16'hFFFF);
        // length extremes
        issue(OP_MOV, 0, 0, REG_BP, SRC_NONE, REG_NONE, 16'h0000, REG_NONE, REG_NONE, 16'h0000);
        issue(OP_ADD, 7, 0, REG_BP, SRC_MEM, REG_NONE, 16'h0000, REG_AX, REG_NONE, 16'hFFFF);

        // sender waits out every outstanding result once before the random part
        wait_results_drained();

        for (int i = 0; i < RANDOM_ROUNDS; i++) begin
            k = $urandom_range(0, 99);
            if (k < 20) begin
                // store then read back through the same effective address
                ea_a = pick_ea_reg();
                ea_b = pick_ea_reg();
                disp = pick_disp();
                issue(OP_MOV, 3'($urandom_range(2, 6)), 1, pick_reg(),
                      2'($urandom_range(SRC_IMM, SRC_REG)), pick_reg(), pick_word(),
                      ea_a, ea_b, disp);
                issue(3'($urandom_range(OP_MOV, OP_CMP)), 3'($urandom_range(2, 6)), 0,
                      pick_reg(), SRC_MEM, pick_reg(), pick_word(), ea_a, ea_b, disp);
            end else if (k < 32) begin
                // compare then conditional branch
                r = pick_reg();
                issue(OP_CMP, 3'($urandom_range(2, 4)), 1'($urandom_range(0, 1)), r,
                      2'($urandom_range(SRC_NONE, SRC_MEM)),
                      ($urandom_range(0, 1) != 0) ? r : pick_reg(), pick_word(),
                      pick_ea_reg(), pick_ea_reg(), pick_disp());
                issue(OP_JNE, 2, 1'($urandom_range(0, 1)), pick_reg(),
                      2'($urandom_range(SRC_NONE, SRC_MEM)), pick_reg(), pick_word(),
                      pick_ea_reg(), pick_ea_reg(), pick_disp());
            end else begin
                issue(pick_mode(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      pick_reg(), 2'($urandom_range(SRC_NONE, SRC_MEM)), pick_reg(),
                      pick_word(), pick_ea_reg(), pick_ea_reg(), pick_disp());
            end
            // another full drain in the middle of the random part
            if (i == RANDOM_ROUNDS / 2) begin
                wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (20) @(posedge aclk);

        $display("ran %0d instructions (%0d memory stores, %0d jne), %0d results compared",
                 n_sent, n_stores, n_branches, n_checked);
        if (n_errors == 0 && n_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
